// ===== sv/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

   // Fields of one received byte request.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Fields of one result: an unmasked payload byte or a frame status.
   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [3:0]  frame_opcode;
      logic [31:0] payload_length;
      logic [1:0]  status;
      logic        end_of_frame;
   } rsp_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Status codes and the close codes they stand for.
   localparam logic [1:0] ST_OK     = 2'd0;  // normal
   localparam logic [1:0] ST_PROTO  = 2'd1;  // close code 1002
   localparam logic [1:0] ST_OPCODE = 2'd2;  // close code 1008
   localparam logic [1:0] ST_BIG    = 2'd3;  // close code 1009

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Header byte positions that close each header section.
   localparam logic [3:0] IDX_EXT16_END = 4'd4;
   localparam logic [3:0] IDX_EXT64_HI  = 4'd6;
   localparam logic [3:0] IDX_EXT64_END = 4'd10;
   localparam logic [3:0] IDX_KEY_END   = 4'd4;
   localparam logic [3:0] IDX_AFTER_LEN = 4'd2;

   localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== sv/wsd_rsp_queue.sv =====
`default_nettype none

module wsd_rsp_queue
   import wsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push0,
   input  wire rsp_type push0_data,
   input  wire logic    push1,
   input  wire rsp_type push1_data,
   output logic         room_for_two,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   rsp_type               entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  pop;
   logic [PtrWidth-1:0]   wr_ptr_next;

   assign pop          = rsp_valid && rsp_ready;
   assign rsp_valid    = (count_ff != '0);
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CntWidth'(QUEUE_DEPTH - 2));
   assign wr_ptr_next  = wr_ptr_ff + PtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push0 && push1) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(2);
      end else if (push0) begin
         wr_ptr_in = wr_ptr_next;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
      end
      count_in = count_ff + CntWidth'(push0) + CntWidth'(push1) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= push0_data;
      end
      if (push0 && push1) begin
         entry_ff[wr_ptr_next] <= push1_data;
      end
   end

   a_push1_needs_push0 : assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second result pushed without a first");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push0 |-> (count_ff + CntWidth'(push1) < CntWidth'(QUEUE_DEPTH)) || pop)
      else $error("result queue overflow");

   a_pop_only_drains : assert property (@(posedge clock) disable iff (reset)
      (!reset && pop && !push0) |=> (count_ff == $past(count_ff) - CntWidth'(1)))
      else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

// ===== sv/websocket_frame_deframer_core.sv =====
`default_nettype none

// Receive-side WebSocket deframer. Bytes of one message enter as requests on
// req_*, the final byte flagged by last_byte. Every payload byte leaves as a
// result XORed with its masking key byte, and every message ends with one
// status result (ok, or an error that maps to close code 1002, 1008 or 1009);
// after an error the rest of the message is dropped. One byte is accepted
// per cycle while the result queue has room: the header check, length and key
// capture and the unmasking all happen in the cycle the byte is accepted,
// and results go into a four-entry result queue. Requests are taken while
// that queue holds at most two results, so a byte that yields both its last
// payload byte and the status always finds room, and throughput is one byte
// per cycle as long as rsp_ready stays high.
module websocket_frame_deframer_core
   import wsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_PAYLOAD,
      PH_DISCARD,
      PH_HDR1BAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_index_ff, header_index_in;
   logic [3:0]  held_opcode_ff, held_opcode_in;
   logic [31:0] length_value_ff, length_value_in;
   logic [31:0] payload_count_ff, payload_count_in;
   logic        oversize_ff, oversize_in;
   logic [7:0]  mask_key_ff [4];

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic [3:0]  index_inc;
   logic [31:0] count_inc;
   logic        key_write;
   logic        emit_pay;
   logic        emit_stat;
   logic [1:0]  stat_code;
   logic [7:0]  pay_byte;
   rsp_type     pay_rsp;
   rsp_type     stat_rsp;
   logic        room_for_two;

   assign accept    = req_valid && req_ready;
   assign req_ready = room_for_two;
   assign b         = req_data.data_byte;
   assign last      = req_data.last_byte;
   assign index_inc = header_index_ff + 4'd1;
   assign count_inc = payload_count_ff + 32'd1;

   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      held_opcode_in   = held_opcode_ff;
      length_value_in  = length_value_ff;
      payload_count_in = payload_count_ff;
      oversize_in      = oversize_ff;
      key_write        = 1'b0;
      emit_pay         = 1'b0;
      emit_stat        = 1'b0;
      stat_code        = ST_PROTO;
      pay_byte         = b ^ mask_key_ff[payload_count_ff[1:0]];

      case (phase_ff)
         PH_HDR0: begin
            held_opcode_in = b[3:0];
            if (last) begin
               emit_stat = 1'b1;
               phase_in  = PH_HDR0;
            end else if (!b[7] || (b[6:4] != 3'b000)) begin
               phase_in = PH_HDR1BAD;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1BAD: begin
            emit_stat = 1'b1;
            phase_in  = last ? PH_HDR0 : PH_DISCARD;
         end
         PH_HDR1: begin
            if (!(held_opcode_ff inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
            begin
               emit_stat = 1'b1;
               stat_code = ST_OPCODE;
               phase_in  = last ? PH_HDR0 : PH_DISCARD;
            end else if (!b[7]) begin
               emit_stat = 1'b1;
               phase_in  = last ? PH_HDR0 : PH_DISCARD;
            end else begin
               length_value_in = '0;
               header_index_in = IDX_AFTER_LEN;
               if (b[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (b[6:0] == LEN_EXT64) begin
                  phase_in    = PH_EXT64;
                  oversize_in = 1'b0;
               end else begin
                  length_value_in = {25'd0, b[6:0]};
                  phase_in        = PH_KEY;
                  header_index_in = '0;
               end
               if (last) begin
                  emit_stat = 1'b1;
                  phase_in  = PH_HDR0;
               end
            end
         end
         PH_EXT16: begin
            length_value_in = {length_value_ff[23:0], b};
            header_index_in = index_inc;
            if (index_inc >= IDX_EXT16_END) begin
               phase_in        = PH_KEY;
               header_index_in = '0;
            end
            if (last) begin
               emit_stat = 1'b1;
               phase_in  = PH_HDR0;
            end
         end
         PH_EXT64: begin
            // The upper four length bytes only flag a length that cannot fit.
            if (header_index_ff < IDX_EXT64_HI) begin
               if (b != 8'd0) begin
                  oversize_in = 1'b1;
               end
            end else begin
               length_value_in = {length_value_ff[23:0], b};
            end
            header_index_in = index_inc;
            if ((index_inc >= IDX_EXT64_END) && oversize_ff) begin
               emit_stat = 1'b1;
               stat_code = ST_BIG;
               phase_in  = last ? PH_HDR0 : PH_DISCARD;
            end else begin
               if (index_inc >= IDX_EXT64_END) begin
                  phase_in        = PH_KEY;
                  header_index_in = '0;
               end
               if (last) begin
                  emit_stat = 1'b1;
                  phase_in  = PH_HDR0;
               end
            end
         end
         PH_KEY: begin
            key_write       = 1'b1;
            header_index_in = index_inc;
            if (index_inc >= IDX_KEY_END) begin
               phase_in         = PH_PAYLOAD;
               payload_count_in = '0;
               if (last) begin
                  emit_stat = 1'b1;
                  stat_code = (length_value_ff == 32'd0) ? ST_OK : ST_PROTO;
                  phase_in  = PH_HDR0;
               end
            end else if (last) begin
               emit_stat = 1'b1;
               phase_in  = PH_HDR0;
            end
         end
         PH_PAYLOAD: begin
            if (payload_count_ff < length_value_ff) begin
               emit_pay         = 1'b1;
               payload_count_in = count_inc;
               if (last) begin
                  emit_stat = 1'b1;
                  stat_code = (count_inc == length_value_ff) ? ST_OK : ST_PROTO;
                  phase_in  = PH_HDR0;
               end
            end else begin
               // A byte beyond the declared length is an error.
               emit_stat = 1'b1;
               phase_in  = last ? PH_HDR0 : PH_DISCARD;
            end
         end
         PH_DISCARD: begin
            if (last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
   end

   always_comb begin
      pay_rsp                = '0;
      pay_rsp.kind           = KIND_PAYLOAD;
      pay_rsp.payload_byte   = pay_byte;

      stat_rsp                = '0;
      stat_rsp.kind           = KIND_STATUS;
      stat_rsp.frame_opcode   = held_opcode_in;
      stat_rsp.payload_length = (stat_code == ST_OK) ? length_value_in : 32'd0;
      stat_rsp.status         = stat_code;
      stat_rsp.end_of_frame   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR0;
         header_index_ff  <= '0;
         held_opcode_ff   <= '0;
         length_value_ff  <= '0;
         payload_count_ff <= '0;
         oversize_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         held_opcode_ff   <= held_opcode_in;
         length_value_ff  <= length_value_in;
         payload_count_ff <= payload_count_in;
         oversize_ff      <= oversize_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && key_write) begin
         mask_key_ff[header_index_ff[1:0]] <= b;
      end
   end

   // The payload byte, when there is one, always goes ahead of the status.
   wsd_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push0        (accept && (emit_pay || emit_stat)),
      .push0_data   (emit_pay ? pay_rsp : stat_rsp),
      .push1        (accept && emit_pay && emit_stat),
      .push1_data   (stat_rsp),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && last) |=> (phase_ff == PH_HDR0))
      else $error("final byte did not return to header start");

   a_payload_counts : assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && emit_pay) |=>
         (payload_count_ff == $past(payload_count_ff) + 32'd1))
      else $error("payload count did not advance with a payload byte");

   a_status_ends_run : assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && emit_stat && !last) |=> (phase_ff == PH_DISCARD))
      else $error("status before the final byte did not start discarding");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import wsd_pkg::*;

   localparam int ITEM_TARGET = 1930;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [3:0] OP_CONT = 4'h0;
   localparam logic [3:0] GOOD_OPS [5] = '{OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

   typedef logic [7:0] frame_bytes_type[$];

   typedef enum logic [2:0] {
      WAIT_HDR0,
      WAIT_HDR1,
      GET_EXT16,
      GET_EXT64,
      GET_KEY,
      GET_PAYLOAD,
      SKIP_REST,
      HDR0_REJECTED
   } deframe_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type rx_bytes_q[$];
   rsp_type deframed_q[$];
   int      drain_at[$] = '{31, 640, 1400};
   int      sent_idx = 0;
   int      error_count = 0;
   int      cycles = 0;
   logic    req_taken = 1'b0;

   // Shadow of the deframer state.
   deframe_phase_type phase_q = WAIT_HDR0;
   logic [3:0]        hdr_pos_q = '0;
   logic [3:0]        opcode_q = '0;
   logic [31:0]       length_q = '0;
   logic [31:0]       count_q = '0;
   logic [7:0]        key_q [4];
   logic              oversize_q = 1'b0;

   websocket_frame_deframer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic known_opcode(logic [3:0] op);
      return op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE || op == OP_PING
             || op == OP_PONG;
   endfunction

   function automatic logic [7:0] first_byte(logic [3:0] op);
      return {4'b1000, op};
   endfunction

   function automatic logic [7:0] len_byte(logic masked, logic [6:0] len7);
      return {masked, len7};
   endfunction

   // Every status ends the run; the rest of the message is dropped unless
   // this byte was the last one.
   task automatic close_run(input logic [1:0] st, input logic at_end);
      rsp_type s;
      s = '0;
      s.kind = KIND_STATUS;
      s.frame_opcode = opcode_q;
      s.payload_length = (st == ST_OK) ? length_q : 32'd0;
      s.status = st;
      s.end_of_frame = 1'b1;
      deframed_q.push_back(s);
      phase_q = at_end ? WAIT_HDR0 : SKIP_REST;
   endtask

   task automatic deframe_byte(input req_type rx);
      rsp_type    pay;
      logic [7:0] b;
      b = rx.data_byte;
      case (phase_q)
         WAIT_HDR0: begin
            opcode_q = b[3:0];
            if (rx.last_byte) begin
               close_run(ST_PROTO, 1'b1);
            end else if (!b[7] || b[6:4] != 3'b000) begin
               phase_q = HDR0_REJECTED;
            end else begin
               phase_q = WAIT_HDR1;
            end
         end
         HDR0_REJECTED: begin
            close_run(ST_PROTO, rx.last_byte);
         end
         WAIT_HDR1: begin
            if (!known_opcode(opcode_q)) begin
               close_run(ST_OPCODE, rx.last_byte);
            end else if (!b[7]) begin
               close_run(ST_PROTO, rx.last_byte);
            end else begin
               length_q = '0;
               hdr_pos_q = IDX_AFTER_LEN;
               if (b[6:0] == LEN_EXT16) begin
                  phase_q = GET_EXT16;
               end else if (b[6:0] == LEN_EXT64) begin
                  phase_q = GET_EXT64;
                  oversize_q = 1'b0;
               end else begin
                  length_q = 32'(b[6:0]);
                  phase_q = GET_KEY;
                  hdr_pos_q = '0;
               end
               if (rx.last_byte) close_run(ST_PROTO, 1'b1);
            end
         end
         GET_EXT16: begin
            length_q = {length_q[23:0], b};
            hdr_pos_q++;
            if (hdr_pos_q >= IDX_EXT16_END) begin
               phase_q = GET_KEY;
               hdr_pos_q = '0;
            end
            if (rx.last_byte) close_run(ST_PROTO, 1'b1);
         end
         GET_EXT64: begin
            // The upper half of a 64-bit length only marks the frame as too big.
            if (hdr_pos_q < IDX_EXT64_HI) begin
               if (b != 8'h00) oversize_q = 1'b1;
            end else begin
               length_q = {length_q[23:0], b};
            end
            hdr_pos_q++;
            if (hdr_pos_q >= IDX_EXT64_END && oversize_q) begin
               close_run(ST_BIG, rx.last_byte);
            end else begin
               if (hdr_pos_q >= IDX_EXT64_END) begin
                  phase_q = GET_KEY;
                  hdr_pos_q = '0;
               end
               if (rx.last_byte) close_run(ST_PROTO, 1'b1);
            end
         end
         GET_KEY: begin
            key_q[hdr_pos_q[1:0]] = b;
            hdr_pos_q++;
            if (hdr_pos_q >= IDX_KEY_END) begin
               phase_q = GET_PAYLOAD;
               count_q = '0;
               if (rx.last_byte) close_run((length_q == 0) ? ST_OK : ST_PROTO, 1'b1);
            end else if (rx.last_byte) begin
               close_run(ST_PROTO, 1'b1);
            end
         end
         GET_PAYLOAD: begin
            if (count_q < length_q) begin
               pay = '0;
               pay.kind = KIND_PAYLOAD;
               pay.payload_byte = b ^ key_q[count_q[1:0]];
               deframed_q.push_back(pay);
               count_q++;
               if (rx.last_byte) begin
                  close_run((count_q == length_q) ? ST_OK : ST_PROTO, 1'b1);
               end
            end else begin
               close_run(ST_PROTO, rx.last_byte);
            end
         end
         default: begin
            if (rx.last_byte) phase_q = WAIT_HDR0;
         end
      endcase
   endtask

   task automatic queue_frame(input frame_bytes_type msg);
      req_type item;
      foreach (msg[i]) begin
         item.data_byte = msg[i];
         item.last_byte = (i == msg.size() - 1);
         rx_bytes_q.push_back(item);
      end
   endtask

   task automatic queue_random_frame();
      frame_bytes_type msg;
      logic [7:0]      hb;
      logic [3:0]      op;
      logic [31:0]     decl;
      int              pick;
      int              fmt;
      int              sent;
      int              cut;
      pick = $urandom_range(0, 99);
      msg = {};
      if (pick < 72) begin
         msg.push_back(first_byte(GOOD_OPS[$urandom_range(0, 4)]));
         fmt = $urandom_range(0, 9);
         if (fmt < 6) begin
            decl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
            msg.push_back(len_byte(1'b1, decl[6:0]));
         end else if (fmt < 9) begin
            case ($urandom_range(0, 9))
               0: decl = $urandom_range(0, 65535);
               1: decl = $urandom_range(126, 300);
               default: decl = $urandom_range(0, 24);
            endcase
            msg.push_back(len_byte(1'b1, LEN_EXT16));
            msg.push_back(decl[15:8]);
            msg.push_back(decl[7:0]);
         end else begin
            decl = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 24);
            msg.push_back(len_byte(1'b1, LEN_EXT64));
            repeat (4) msg.push_back(8'h00);
            for (int i = 3; i >= 0; i--) msg.push_back(decl[8*i +: 8]);
         end
         repeat (4) msg.push_back(8'($urandom()));
         // Huge declared lengths can only be sent cut short.
         sent = (decl > 300) ? $urandom_range(0, 20) : int'(decl);
         repeat (sent) msg.push_back(8'($urandom()));
         case ($urandom_range(0, 9))
            0: begin
               cut = $urandom_range(1, msg.size() - 1);
               msg = msg[0 : cut - 1];
            end
            1: repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom()));
            default: ;
         endcase
      end else if (pick < 79) begin
         do hb = 8'($urandom()); while (hb[7] && hb[6:4] == 3'b000);
         msg.push_back(hb);
         repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom()));
      end else if (pick < 85) begin
         do op = 4'($urandom()); while (known_opcode(op));
         msg.push_back(first_byte(op));
         repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom()));
      end else if (pick < 90) begin
         msg.push_back(first_byte(GOOD_OPS[$urandom_range(0, 4)]));
         msg.push_back(len_byte(1'b0, 7'($urandom())));
         repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom()));
      end else if (pick < 95) begin
         msg.push_back(first_byte(GOOD_OPS[$urandom_range(0, 4)]));
         msg.push_back(len_byte(1'b1, LEN_EXT64));
         repeat (12) msg.push_back(8'($urandom()));
         msg[2 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
         cut = $urandom_range(2, 14);
         msg = msg[0 : cut - 1];
      end else begin
         repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom()));
      end
      queue_frame(msg);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Request driver: inputs change on the falling edge.
   always @(negedge clock) begin : driver
      logic calm;
      logic draining;
      calm = sent_idx >= 900 && sent_idx < 1250;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
         if (!req_valid || req_taken) begin
            draining = drain_at.size() != 0 && sent_idx == drain_at[0];
            if (draining && deframed_q.size() == 0) begin
               void'(drain_at.pop_front());
               draining = 1'b0;
            end
            if (rx_bytes_q.size() != 0 && !draining && (calm || $urandom_range(0, 99) >= 31)) begin
               req_valid <= 1'b1;
               req_data <= rx_bytes_q.pop_front();
               sent_idx++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each accepted request and checks each result.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) deframe_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = deframed_q.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_data.payload_byte));
               check_field("frame_opcode", 32'(want.frame_opcode), 32'(rsp_data.frame_opcode));
               check_field("payload_length", want.payload_length, rsp_data.payload_length);
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("end_of_frame", 32'(want.end_of_frame), 32'(rsp_data.end_of_frame));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** websocket_frame_deframer_core: FAILED **");
         $finish;
      end
   end

   initial begin
      frame_bytes_type msg;

      // One-byte message.
      msg = {first_byte(OP_TEXT)};
      queue_frame(msg);
      // FIN clear and all reserved bits set.
      msg = {{4'b0111, OP_TEXT}, len_byte(1'b1, 7'd0)};
      queue_frame(msg);
      // Continuation opcode is not accepted.
      msg = {first_byte(OP_CONT), len_byte(1'b1, 7'd5)};
      queue_frame(msg);
      // Mask bit clear.
      msg = {first_byte(OP_BINARY), len_byte(1'b0, 7'd5)};
      queue_frame(msg);
      // Zero length, message ends right after the key.
      msg = {first_byte(OP_PONG), len_byte(1'b1, 7'd0), 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      queue_frame(msg);
      // 64-bit length with the top bit set.
      msg = {first_byte(OP_CLOSE), len_byte(1'b1, LEN_EXT64), 8'h80, 8'h00, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h01};
      queue_frame(msg);
      // One byte beyond the declared length.
      msg = {first_byte(OP_PING), len_byte(1'b1, 7'd1), 8'hFF, 8'h00, 8'hA5, 8'h5A,
             8'h00, 8'hFF};
      queue_frame(msg);

      while (rx_bytes_q.size() < ITEM_TARGET) queue_random_frame();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (rx_bytes_q.size() != 0 || req_valid) @(posedge clock);
      while (deframed_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && deframed_q.size() == 0) begin
         $display("** websocket_frame_deframer_core: PASSED **");
      end else begin
         $display("** websocket_frame_deframer_core: FAILED **");
      end
      $finish;
   end

endmodule
